>>> rtl/bqlp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the three-channel biquad low-pass filter.
package bqlp_pkg;

  // Field and datapath widths
  localparam int DATA_W     = 32;  // Q16.16 samples and delay state
  localparam int COEF_W     = 24;  // Q2.22 coefficients
  localparam int CH_W       = 2;   // channel number field
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;  // three products, exact
  localparam int FRAC_SHIFT = 22;

  // Configuration port
  localparam int REG_COUNT = 6;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 5;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DATA_W-1:0] sample_t;
  typedef coef_t [REG_COUNT-1:0]    coef_bank_t;

  localparam coef_t COEF_ONE = coef_t'(24'sd4194304);

  // Register map, in address order
  typedef enum logic [2:0] {
    REG_A0 = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B0 = 3'd3,
    REG_B1 = 3'd4,
    REG_B2 = 3'd5
  } reg_idx_t;

  // One request to the shared multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic clear;   // start a new sum with this product
    logic negate;  // subtract this product
  } mac_op_t;

  // Sequencer status seen at the top level
  typedef struct packed {
    logic busy;
    logic done;
  } ctrl_stat_t;

endpackage

>>> rtl/bqlp_ifs.sv
`timescale 1ns / 1ps
// Request channel interfaces of the biquad filter (sample in, filtered value out).
interface bqlp_in_if;
  logic                     valid;
  logic                     ready;
  logic [bqlp_pkg::CH_W-1:0] channel;
  bqlp_pkg::sample_t        sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface bqlp_out_if;
  logic                     valid;
  logic                     ready;
  logic [bqlp_pkg::CH_W-1:0] channel_out;
  bqlp_pkg::sample_t        filtered;

  modport source (output valid, output channel_out, output filtered, input ready);
  modport sink   (input valid, input channel_out, input filtered, output ready);
endinterface

>>> rtl/biquad_lowpass_three_channel.sv
`timescale 1ns / 1ps
// Top level of the three-channel direct form II biquad low-pass filter.
//
//  port group  dir  handshake           payload
//  in_chan     in   valid/ready         channel, sample_in (Q16.16)
//  out_chan    out  valid/ready         channel_out, filtered (Q16.16)
//  cfg_*       in   APB, pready high    six Q2.22 coefficients at 4*i
//
// A request is accepted, then six products pass through the one shared
// multiply-accumulate unit and two round/saturate steps before the result
// is registered. An unknown channel skips the arithmetic and registers a
// zero result; the next request is taken once the sequencer is idle again.
// Synchronous active-low reset clears delays and restores a0 = b0 = 1.0.
// A new request is taken while a result waits; the sequencer holds in its
// last step until the output register is free.
module biquad_lowpass_three_channel #(
  parameter int CHANNELS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bqlp_in_if.sink                      in_chan,
  bqlp_out_if.source                   out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bqlp_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bqlp_pkg::APB_W-1:0]   cfg_pwdata,
  output logic [bqlp_pkg::APB_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  bqlp_pkg::coef_bank_t  coefs;
  bqlp_pkg::mac_op_t     mac_op;
  bqlp_pkg::coef_t       mac_coef;
  bqlp_pkg::sample_t     mac_data;
  bqlp_pkg::sample_t     rnd_q;
  bqlp_pkg::ctrl_stat_t  stat;

  // coefficient registers
  bqlp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coefs       (coefs)
  );

  // shared arithmetic
  bqlp_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (mac_op),
    .coef_i (mac_coef),
    .data_i (mac_data),
    .rnd_q  (rnd_q)
  );

  // sequencer and state
  bqlp_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .coefs    (coefs),
    .rnd_q    (rnd_q),
    .op       (mac_op),
    .coef_o   (mac_coef),
    .data_o   (mac_data),
    .stat     (stat)
  );

  // the arithmetic unit only runs while a request is in hand
  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> !mac_op.valid)
    else $error("multiply issued while idle");

  // a taken request blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input ready after accept");

  // finishing a request always presents a result
  a_done_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_chan.valid)
    else $error("result lost on completion");

  // a result only appears from a finishing request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(stat.done))
    else $error("result without a request");

endmodule

>>> rtl/bqlp_cfg.sv
`timescale 1ns / 1ps
// APB coefficient register bank of the biquad filter.
module bqlp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bqlp_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [bqlp_pkg::APB_W-1:0]    cfg_pwdata,
  output logic [bqlp_pkg::APB_W-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output bqlp_pkg::coef_bank_t          coefs
);

  bqlp_pkg::coef_bank_t coefs_r;
  logic [2:0]           reg_idx;
  logic                 idx_ok;
  logic                 wr_en;

  // word index, byte lanes ignored
  assign reg_idx    = cfg_paddr[4:2];
  assign idx_ok     = int'(reg_idx) < bqlp_pkg::REG_COUNT;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && idx_ok;
  assign cfg_pready = 1'b1;
  assign coefs      = coefs_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // b2, b1, b0, a2, a1, a0: only a0 and b0 come up at one
      coefs_r <= {bqlp_pkg::coef_t'(0), bqlp_pkg::coef_t'(0), bqlp_pkg::COEF_ONE,
                  bqlp_pkg::coef_t'(0), bqlp_pkg::coef_t'(0), bqlp_pkg::COEF_ONE};
    end else if (wr_en) begin
      coefs_r[reg_idx] <= bqlp_pkg::coef_t'(cfg_pwdata[bqlp_pkg::COEF_W-1:0]);
    end
  end

  // read-back, sign extended
  always_comb begin
    cfg_prdata = '0;
    if (idx_ok) begin
      cfg_prdata = {{(bqlp_pkg::APB_W - bqlp_pkg::COEF_W){coefs_r[reg_idx][bqlp_pkg::COEF_W-1]}},
                    coefs_r[reg_idx]};
    end
  end

endmodule

>>> rtl/bqlp_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with round-to-nearest and saturation.
module bqlp_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bqlp_pkg::mac_op_t    op,
  input  bqlp_pkg::coef_t      coef_i,
  input  bqlp_pkg::sample_t    data_i,
  output bqlp_pkg::sample_t    rnd_q
);

  localparam int ACC_W  = bqlp_pkg::ACC_W;
  localparam int PROD_W = bqlp_pkg::PROD_W;
  localparam int SH     = bqlp_pkg::FRAC_SHIFT;
  localparam int DW     = bqlp_pkg::DATA_W;
  localparam int QW     = ACC_W + 1 - SH;

  logic signed [PROD_W-1:0] prod_r;
  bqlp_pkg::mac_op_t        op_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W:0]    biased;
  logic signed [QW-1:0]     quot;
  logic                     in_range;

  // stage 1: product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (op.valid) begin
      prod_r <= coef_i * data_i;
    end
  end

  // stage 2: accumulate, Q20.38
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_base = op_r.clear ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (op_r.valid) begin
      acc_r <= op_r.negate ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end
  end

  // round half up to Q16.16, then clamp to 32 bits
  assign biased   = {acc_r[ACC_W-1], acc_r} + ((ACC_W+1)'(1) << (SH - 1));
  assign quot     = biased[ACC_W:SH];
  assign in_range = (&quot[QW-1:DW-1]) || !(|quot[QW-1:DW-1]);

  always_comb begin
    if (in_range) begin
      rnd_q = quot[DW-1:0];
    end else if (quot[QW-1]) begin
      rnd_q = {1'b1, {(DW-1){1'b0}}};
    end else begin
      rnd_q = {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

>>> rtl/bqlp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer, per-channel delay store and result register of the biquad filter.
module bqlp_ctrl #(
  parameter int CHANNELS = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  bqlp_in_if.sink                in_chan,
  bqlp_out_if.source             out_chan,
  input  bqlp_pkg::coef_bank_t   coefs,
  input  bqlp_pkg::sample_t      rnd_q,
  output bqlp_pkg::mac_op_t      op,
  output bqlp_pkg::coef_t        coef_o,
  output bqlp_pkg::sample_t      data_o,
  output bqlp_pkg::ctrl_stat_t   stat
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_A0, S_A1, S_A2, S_B1, S_B2, S_B0, S_WAIT, S_DONE
  } state_t;

  state_t                     state_r;
  logic [bqlp_pkg::CH_W-1:0]  ch_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       live_r;
  bqlp_pkg::sample_t          x_r, w1_r, w2_r, w0_r;
  bqlp_pkg::sample_t          dly1_r [CHANNELS];
  bqlp_pkg::sample_t          dly2_r [CHANNELS];
  logic                       out_valid_r;
  logic [bqlp_pkg::CH_W-1:0]  out_ch_r;
  bqlp_pkg::sample_t          out_y_r;

  logic                       accept;
  logic                       out_free;
  logic                       ch_ok;
  logic [IDX_W-1:0]           idx_in;

  assign in_chan.ready        = (state_r == S_IDLE);
  assign accept               = in_chan.valid && in_chan.ready;
  assign out_free             = !out_valid_r || out_chan.ready;
  assign ch_ok                = int'(in_chan.channel) < CHANNELS;
  assign idx_in               = IDX_W'(in_chan.channel);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.channel_out = out_ch_r;
  assign out_chan.filtered    = out_y_r;

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE) && out_free;

  // operand select: w0 sum first, then b1*w1, b2*w2, b0*w0
  always_comb begin
    op     = '0;
    coef_o = '0;
    data_o = '0;
    case (state_r)
      S_A0: begin
        op = '{valid: 1'b1, clear: 1'b1, negate: 1'b0};
        coef_o = coefs[bqlp_pkg::REG_A0];
        data_o = x_r;
      end
      S_A1: begin
        op = '{valid: 1'b1, clear: 1'b0, negate: 1'b1};
        coef_o = coefs[bqlp_pkg::REG_A1];
        data_o = w1_r;
      end
      S_A2: begin
        op = '{valid: 1'b1, clear: 1'b0, negate: 1'b1};
        coef_o = coefs[bqlp_pkg::REG_A2];
        data_o = w2_r;
      end
      S_B1: begin
        op = '{valid: 1'b1, clear: 1'b1, negate: 1'b0};
        coef_o = coefs[bqlp_pkg::REG_B1];
        data_o = w1_r;
      end
      S_B2: begin
        op = '{valid: 1'b1, clear: 1'b0, negate: 1'b0};
        coef_o = coefs[bqlp_pkg::REG_B2];
        data_o = w2_r;
      end
      S_B0: begin
        op = '{valid: 1'b1, clear: 1'b0, negate: 1'b0};
        coef_o = coefs[bqlp_pkg::REG_B0];
        data_o = w0_r;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  // state, operands, delay store and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        dly1_r[i] <= '0;
        dly2_r[i] <= '0;
      end
    end else begin
      // result valid: set on completion, cleared once taken
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            ch_r   <= in_chan.channel;
            idx_r  <= idx_in;
            live_r <= ch_ok;
            x_r    <= in_chan.sample_in;
            w1_r   <= dly1_r[idx_in];
            w2_r   <= dly2_r[idx_in];
            // unknown channel: no arithmetic, result is zero
            state_r <= ch_ok ? S_A0 : S_DONE;
          end
        end
        S_A0:   state_r <= S_A1;
        S_A1:   state_r <= S_A2;
        S_A2:   state_r <= S_B1;
        S_B1:   state_r <= S_B2;
        S_B2: begin
          w0_r    <= rnd_q;  // first sum is complete here
          state_r <= S_B0;
        end
        S_B0:   state_r <= S_WAIT;
        S_WAIT: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_ch_r    <= ch_r;
            out_y_r     <= live_r ? rnd_q : '0;
            if (live_r) begin
              dly2_r[idx_r] <= w1_r;
              dly1_r[idx_r] <= w0_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
